// ===== rtl/abf_pkg.sv =====
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types, result codes and the sample-rate decode of the audio block FIFO.
// ----------------------------------------------------------------------------
package abf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RATE_W   = 19;
    localparam int STATUS_W = 3;
    localparam int BQ_OUT_W = 4;
    localparam int FILL_W   = 10;
    localparam int SHIFT_W  = 2;

    localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP_LONG = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    localparam logic [RATE_W-1:0] RATE_384K = 19'd384000;
    localparam logic [RATE_W-1:0] RATE_352K = 19'd352800;
    localparam logic [RATE_W-1:0] RATE_192K = 19'd192000;
    localparam logic [RATE_W-1:0] RATE_176K = 19'd176400;
    localparam logic [RATE_W-1:0] RATE_96K  = 19'd96000;
    localparam logic [RATE_W-1:0] RATE_88K  = 19'd88200;
    localparam logic [RATE_W-1:0] RATE_48K  = 19'd48000;
    localparam logic [RATE_W-1:0] RATE_44K  = 19'd44100;

    typedef enum logic {
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                block_end;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
        logic [BQ_OUT_W-1:0] blocks;
        logic [FILL_W-1:0]   fill;
    } t_result;

    // Oversampling shift for the fill level. The base rates and any other value
    // fall to the default arm.
    function automatic logic [SHIFT_W-1:0] rate_shift(input logic [RATE_W-1:0] rate);
        logic [SHIFT_W-1:0] shift;
        unique case (rate) inside
            RATE_384K, RATE_352K: shift = 2'd0;
            RATE_192K, RATE_176K: shift = 2'd1;
            RATE_96K,  RATE_88K:  shift = 2'd2;
            default:              shift = 2'd3;
        endcase
        return shift;
    endfunction

endpackage

// ===== rtl/abf_front.sv =====
// ----------------------------------------------------------------------------
// abf_front
// Input side: classifies each beat into a push or pop command and holds it in
// a two-entry queue for the executor.
// ----------------------------------------------------------------------------
module abf_front
    import abf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [SAMPLE_W-1:0] i_left,
    input  logic [SAMPLE_W-1:0] i_right,
    input  logic                i_block_end,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output t_cmd                o_cmd
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.op        = i_kind ? OP_POP : OP_PUSH;
        w_cmd.left      = i_left;
        w_cmd.right     = i_right;
        w_cmd.block_end = i_block_end;
    end

    assign o_ready     = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr_ptr] <= w_cmd;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/abf_back.sv =====
// ----------------------------------------------------------------------------
// abf_back
// Executor: owns the frame store, the block length table and the ring
// pointers, carries out push and pop commands and holds the result register.
// ----------------------------------------------------------------------------
module abf_back
    import abf_pkg::*;
#(
    parameter int BLOCK_COUNT  = 8,
    parameter int BLOCK_FRAMES = 64
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    input  logic [SHIFT_W-1:0] i_shift,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_out
);

    localparam int DEPTH = BLOCK_COUNT * BLOCK_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int WOW   = $clog2(BLOCK_FRAMES + 1);
    localparam int ROW   = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
    localparam int QW    = $clog2(BLOCK_COUNT + 1);
    localparam int FW    = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    logic [2*SAMPLE_W-1:0] frame_store [DEPTH];
    logic [WOW-1:0]        block_lengths [BLOCK_COUNT];

    t_state                r_state;
    logic [BW-1:0]         r_wb;
    logic [BW-1:0]         r_rb;
    logic [WOW-1:0]        r_wo;
    logic [ROW-1:0]        r_ro;
    logic [QW-1:0]         r_bq;
    logic [FW-1:0]         r_fq;
    logic                  r_drop;
    logic                  r_out_valid;
    t_result               r_out;
    logic [2*SAMPLE_W-1:0] r_rd_word;
    logic [WOW-1:0]        r_rd_len;

    t_state                n_state;
    logic [BW-1:0]         n_wb;
    logic [BW-1:0]         n_rb;
    logic [WOW-1:0]        n_wo;
    logic [ROW-1:0]        n_ro;
    logic [QW-1:0]         n_bq;
    logic [FW-1:0]         n_fq;
    logic                  n_drop;
    logic                  n_load;
    t_result               n_out;

    logic                  w_out_free;
    logic                  w_take;
    logic                  w_fs_we;
    logic                  w_len_we;
    logic                  w_rd_en;
    logic                  w_dropping;
    logic [AW-1:0]         w_wr_addr;
    logic [AW-1:0]         w_rd_addr;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_out_free;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_wr_addr   = AW'(r_wb) * AW'(BLOCK_FRAMES) + AW'(r_wo);
    assign w_rd_addr   = AW'(r_rb) * AW'(BLOCK_FRAMES) + AW'(r_ro);
    assign w_dropping  = r_drop || (r_wo == '0 && r_bq >= QW'(BLOCK_COUNT));

    always_comb begin
        n_state  = r_state;
        n_wb     = r_wb;
        n_rb     = r_rb;
        n_wo     = r_wo;
        n_ro     = r_ro;
        n_bq     = r_bq;
        n_fq     = r_fq;
        n_drop   = r_drop;
        n_load   = 1'b0;
        w_fs_we  = 1'b0;
        w_len_we = 1'b0;
        w_rd_en  = 1'b0;
        n_out    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_cmd.op == OP_PUSH) begin
                        n_load = 1'b1;
                        if (w_dropping) begin
                            n_out.status = ST_DROP_FULL;
                            n_drop       = !i_cmd.block_end;
                        end else begin
                            if (r_wo < WOW'(BLOCK_FRAMES)) begin
                                w_fs_we      = 1'b1;
                                n_wo         = r_wo + WOW'(1);
                                n_out.status = ST_PUSHED;
                            end else begin
                                n_out.status = ST_DROP_LONG;
                            end
                            // The closing frame commits the block at its final length.
                            if (i_cmd.block_end) begin
                                w_len_we = 1'b1;
                                n_fq     = r_fq + FW'(n_wo);
                                n_bq     = r_bq + QW'(1);
                                n_wb     = (r_wb == BW'(BLOCK_COUNT - 1)) ? '0 : r_wb + BW'(1);
                                n_wo     = '0;
                            end
                        end
                    end else if (r_bq == '0) begin
                        n_load       = 1'b1;
                        n_out.status = ST_EMPTY;
                    end else begin
                        w_rd_en = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                n_load       = 1'b1;
                n_state      = S_IDLE;
                n_out.status = ST_POPPED;
                n_out.left   = r_rd_word[SAMPLE_W-1:0];
                n_out.right  = r_rd_word[2*SAMPLE_W-1:SAMPLE_W];
                if (r_fq != '0) begin
                    n_fq = r_fq - FW'(1);
                end
                if (WOW'(r_ro) + WOW'(1) >= r_rd_len) begin
                    n_out.last = 1'b1;
                    n_ro       = '0;
                    n_rb       = (r_rb == BW'(BLOCK_COUNT - 1)) ? '0 : r_rb + BW'(1);
                    n_bq       = r_bq - QW'(1);
                end else begin
                    n_ro = r_ro + ROW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out.blocks = BQ_OUT_W'(n_bq);
        n_out.fill   = FILL_W'(n_fq >> i_shift);
    end

    always_ff @(posedge i_clk) begin
        if (w_fs_we) begin
            frame_store[w_wr_addr] <= {i_cmd.right, i_cmd.left};
        end
        if (w_rd_en) begin
            r_rd_word <= frame_store[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            block_lengths[r_wb] <= n_wo == '0 ? (r_wo < WOW'(BLOCK_FRAMES) ? r_wo + WOW'(1)
                                                                           : r_wo)
                                              : n_wo;
        end
        if (w_rd_en) begin
            r_rd_len <= block_lengths[r_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wb        <= '0;
            r_rb        <= '0;
            r_wo        <= '0;
            r_ro        <= '0;
            r_bq        <= '0;
            r_fq        <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wb    <= n_wb;
            r_rb    <= n_rb;
            r_wo    <= n_wo;
            r_ro    <= n_ro;
            r_bq    <= n_bq;
            r_fq    <= n_fq;
            r_drop  <= n_drop;
            if (n_load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/audio_block_fifo.sv =====
// ----------------------------------------------------------------------------
// audio_block_fifo
// Ring of audio blocks with per-block length tracking and a fill-level report.
// ----------------------------------------------------------------------------
// Usage:
// Beats arrive on the s_axis channel: tuser is the kind (0 push, 1 pop), tdata
// carries the left and right samples, tlast closes the block being pushed.
// Every beat returns exactly one beat on m_axis: tuser is the status, tdata
// the popped frame, queued block count and scaled fill level, tlast marks the
// final frame of a block on a pop.
// Input beats land in a two-entry command queue; the executor takes one
// command per cycle for a push or an empty pop while the result register is
// free; a pop also passes through the S_POP state, as the frame store and
// length table have registered read ports. No command is taken in S_POP.
// Each result passes through the command queue and the result register.
// The user must write the sample rate register (i_cfg_wr_en, i_cfg_wr_data)
// only while idle; the block does not enforce this. It resets to 44100 Hz.
// Reset clears the pointers, counters and queues; stored frames keep no reset.
// When the receiver stalls, the result register holds, the executor stops and
// the command queue fills, after which s_axis tready goes low.
// ----------------------------------------------------------------------------
module audio_block_fifo
    import abf_pkg::*;
#(
    parameter int BLOCK_COUNT  = 8,
    parameter int BLOCK_FRAMES = 64
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [63:0]       i_s_axis_tdata,  // left_in[31:0], right_in[63:32]
    input  logic              i_s_axis_tuser,  // kind
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // left_out[31:0], right_out[63:32], blocks_queued_out[67:64],
    // fill_level[77:68], zero [79:78]
    output logic [79:0]       o_m_axis_tdata,
    output logic [2:0]        o_m_axis_tuser,  // status
    output logic              o_m_axis_tlast
);

    logic [RATE_W-1:0] r_sample_rate;
    logic              w_cmd_valid;
    logic              w_cmd_ready;
    t_cmd              w_cmd;
    t_result           w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RATE_44K;
        end else if (i_cfg_wr_en) begin
            r_sample_rate <= i_cfg_wr_data;
        end
    end

    abf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_left      (i_s_axis_tdata[31:0]),
        .i_right     (i_s_axis_tdata[63:32]),
        .i_block_end (i_s_axis_tlast),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    abf_back #(
        .BLOCK_COUNT  (BLOCK_COUNT),
        .BLOCK_FRAMES (BLOCK_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_shift     (rate_shift(r_sample_rate)),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (w_out)
    );

    assign o_m_axis_tdata = {2'b00, w_out.fill, w_out.blocks, w_out.right, w_out.left};
    assign o_m_axis_tuser = w_out.status;
    assign o_m_axis_tlast = w_out.last;

endmodule

// ===== rtl/abf_checker.sv =====
// ----------------------------------------------------------------------------
// abf_checker
// Port-level checks of the audio block FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module abf_checker
    import abf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [79:0]       o_m_axis_tdata,
    input logic [2:0]        o_m_axis_tuser,
    input logic              o_m_axis_tlast
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Only a pop carries samples or a block-end mark.
    a_nonpop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_POPPED |->
            o_m_axis_tdata[63:0] == 64'd0 && !o_m_axis_tlast)
        else $error("samples on a result that is not a pop");

    // An empty pop reports no queued blocks and no queued frames.
    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY |->
            o_m_axis_tdata[77:64] == 14'd0)
        else $error("empty pop with a nonzero fill report");

endmodule

bind audio_block_fifo abf_checker u_abf_checker (.*);
